// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file lru_chk.sv.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Expression must never be true outside reset.
`define CHK_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

// ===== hw/rtl/lru_pkg.sv =====
// Shared constants, types and action codes of the LRU order list.
// No dependencies.
package lru_pkg;

	localparam int DEPTH  = 16;                   // keys held
	localparam int IDX_W  = $clog2(DEPTH);        // slot index
	localparam int CNT_W  = $clog2(DEPTH + 1);    // occupancy (5 bits at 16)
	localparam int KEY_W  = 32;
	localparam int ACT_W  = 2;
	localparam int QDEPTH = 2;                    // command queue, power of two
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [ACT_W-1:0] {
		OP_APPEND = 2'd0,
		OP_EVICT  = 2'd1,
		OP_TOUCH  = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             needs_match;   // touch / remove search the cells
		logic [KEY_W-1:0] key;
	} cmd_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

endpackage

// ===== hw/rtl/lru_req_if.sv =====
// Request channel: one word carries an action and a key.
// Depends on lru_pkg.
interface lru_req_if import lru_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [KEY_W-1:0] key;

	modport source (output valid, action, key, input ready);
	modport sink   (input valid, action, key, output ready);
endinterface

// ===== hw/rtl/lru_rsp_if.sv =====
// Response channel: one word per request.
// Depends on lru_pkg.
interface lru_rsp_if import lru_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] out_key;
	logic             out_valid;
	logic             found;
	logic             overflow;
	logic [CNT_W-1:0] occupancy;

	modport source (output valid, out_key, out_valid, found, overflow, occupancy,
		input ready);
	modport sink   (input valid, out_key, out_valid, found, overflow, occupancy,
		output ready);
endinterface

// ===== hw/rtl/lru_front.sv =====
// Front end: accepts request words, decodes the action, queues commands.
// Depends on lru_pkg and lru_req_if.
module lru_front import lru_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lru_req_if.sink     req,
	output head_t       head,
	input  logic        pop
);

	cmd_t              cmd_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              push;
	logic              do_pop;
	cmd_t              cmd_in;

	assign req.ready = (fill_q != (QPTR_W+1)'(QDEPTH));
	assign push      = req.valid && req.ready;
	assign do_pop    = pop && (fill_q != '0);

	always_comb begin
		cmd_in.key         = req.key;
		cmd_in.op          = OP_APPEND;
		cmd_in.needs_match = 1'b0;
		case (req.action)
			OP_APPEND: cmd_in.op = OP_APPEND;
			OP_EVICT:  cmd_in.op = OP_EVICT;
			OP_TOUCH: begin
				cmd_in.op          = OP_TOUCH;
				cmd_in.needs_match = 1'b1;
			end
			OP_REMOVE: begin
				cmd_in.op          = OP_REMOVE;
				cmd_in.needs_match = 1'b1;
			end
			default: cmd_in.op = OP_APPEND;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, do_pop})
				2'b10:   fill_q <= fill_q + (QPTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (QPTR_W+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign head.valid = (fill_q != '0);
	assign head.cmd   = cmd_q[rd_ptr_q];

endmodule

// ===== hw/rtl/lru_back.sv =====
// Back end: row of key cells, parallel match, shift/insert, response register.
// Depends on lru_pkg and lru_rsp_if.
module lru_back import lru_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  head_t       head,
	output logic        pop,
	lru_rsp_if.source   rsp
);

	typedef enum logic {
		ST_IDLE,
		ST_APPLY
	} state_t;

	state_t            state_q;
	logic [KEY_W-1:0]  slot_q [DEPTH];
	logic [CNT_W-1:0]  count_q;

	// command latched at the match step
	op_t               op_q;
	logic [KEY_W-1:0]  key_q;
	logic [IDX_W-1:0]  pos_q;
	logic              hit_q;

	// response register
	logic              rsp_valid_q;
	logic [KEY_W-1:0]  rsp_key_q;
	logic              rsp_oval_q;
	logic              rsp_found_q;
	logic              rsp_ovf_q;
	logic [CNT_W-1:0]  rsp_occ_q;

	logic [DEPTH-1:0]  match;
	logic [IDX_W-1:0]  pos_first;
	logic [IDX_W-1:0]  pos_last;
	logic              any_match;

	logic              out_free;
	logic              apply_go;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic              shift_en;
	logic [IDX_W-1:0]  shift_pos;
	logic [CNT_W-1:0]  cnt_nx;
	logic [CNT_W-1:0]  cnt_m1;
	logic [KEY_W-1:0]  res_key;
	logic              res_oval;
	logic              res_found;
	logic              res_ovf;

	// match step: compare the head key against every live cell
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match[i] = (slot_q[i] == head.cmd.key) && (CNT_W'(i) < count_q);
		end
		any_match = |match;
		pos_first = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				pos_first = IDX_W'(i);
			end
		end
		pos_last = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match[i]) begin
				pos_last = IDX_W'(i);
			end
		end
	end

	assign pop      = (state_q == ST_IDLE) && head.valid;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign apply_go = (state_q == ST_APPLY) && out_free;
	assign cnt_m1   = count_q - CNT_W'(1);

	// apply step
	always_comb begin
		wr_en     = 1'b0;
		wr_idx    = '0;
		shift_en  = 1'b0;
		shift_pos = '0;
		cnt_nx    = count_q;
		res_key   = '0;
		res_oval  = 1'b0;
		res_found = 1'b0;
		res_ovf   = 1'b0;
		case (op_q)
			OP_APPEND: begin
				if (count_q == CNT_W'(DEPTH)) begin
					res_ovf = 1'b1;
				end else begin
					wr_en  = 1'b1;
					wr_idx = count_q[IDX_W-1:0];
					cnt_nx = count_q + CNT_W'(1);
				end
			end
			OP_EVICT: begin
				if (count_q != '0) begin
					res_key  = slot_q[0];
					res_oval = 1'b1;
					shift_en = 1'b1;
					cnt_nx   = cnt_m1;
				end
			end
			OP_TOUCH: begin
				if (hit_q) begin
					res_found = 1'b1;
					shift_en  = 1'b1;
					shift_pos = pos_q;
					wr_en     = 1'b1;
					wr_idx    = cnt_m1[IDX_W-1:0];
				end
			end
			OP_REMOVE: begin
				if (hit_q) begin
					res_found = 1'b1;
					shift_en  = 1'b1;
					shift_pos = pos_q;
					cnt_nx    = cnt_m1;
				end
			end
			default: cnt_nx = count_q;
		endcase
	end

	// key cells: insert wins over shift
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [KEY_W-1:0] shift_in;
		if (g < DEPTH - 1) begin : g_mid
			assign shift_in = slot_q[g+1];
		end else begin : g_top
			assign shift_in = slot_q[g];
		end
		always_ff @(posedge clk) begin
			if (apply_go) begin
				if (wr_en && (wr_idx == IDX_W'(g))) begin
					slot_q[g] <= key_q;
				end else if (shift_en && (IDX_W'(g) >= shift_pos)) begin
					slot_q[g] <= shift_in;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			op_q        <= OP_APPEND;
			key_q       <= '0;
			pos_q       <= '0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_key_q   <= '0;
			rsp_oval_q  <= 1'b0;
			rsp_found_q <= 1'b0;
			rsp_ovf_q   <= 1'b0;
			rsp_occ_q   <= '0;
		end else begin
			// new word loads the register, otherwise a taken word clears it
			if (apply_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						op_q    <= head.cmd.op;
						key_q   <= head.cmd.key;
						hit_q   <= head.cmd.needs_match && any_match;
						pos_q   <= (head.cmd.op == OP_TOUCH) ? pos_last : pos_first;
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (out_free) begin
						count_q     <= cnt_nx;
						rsp_key_q   <= res_key;
						rsp_oval_q  <= res_oval;
						rsp_found_q <= res_found;
						rsp_ovf_q   <= res_ovf;
						rsp_occ_q   <= cnt_nx;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.out_key   = rsp_key_q;
	assign rsp.out_valid = rsp_oval_q;
	assign rsp.found     = rsp_found_q;
	assign rsp.overflow  = rsp_ovf_q;
	assign rsp.occupancy = rsp_occ_q;

endmodule

// ===== hw/rtl/lru_order_list.sv =====
// Top level of the LRU order list: front end, command queue, back end.
// Depends on lru_pkg, lru_req_if, lru_rsp_if, lru_front, lru_back.
//
//  channel | dir | word                                          | accepted when
//  --------+-----+-----------------------------------------------+--------------
//  req     | in  | action[1:0], key[31:0]                        | valid & ready
//  rsp     | out | out_key, out_valid, found, overflow, occupancy| valid & ready
//
// The back end finishes one request word at a time: it matches the key against
// all DEPTH cells, then shifts/inserts once the response register is free.
// Reset (arst_n low) empties the list and the queue; cell contents are not
// cleared, only cells below the occupancy are ever read.
// A stalled rsp holds its word; the 2-entry queue keeps req open until it fills.
module lru_order_list import lru_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lru_req_if.sink   req,
	lru_rsp_if.source rsp
);

	// head of the command queue and the back end's pop strobe
	head_t head;
	logic  pop;

	// front: decode action, buffer commands
	lru_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.head   (head),
		.pop    (pop)
	);

	// back: key cells, match and update, response register
	lru_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

// ===== hw/rtl/lru_chk.sv =====
// Port-level checks of the LRU order list, bound to the top level.
// Depends on lru_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lru_chk import lru_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [KEY_W-1:0] out_key,
	input logic             out_valid,
	input logic             found,
	input logic             overflow,
	input logic [CNT_W-1:0] occupancy
);

	`CHK_ASSERT(a_rsp_hold, clk, arst_n, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_key) && $stable(occupancy)), "stalled response changed")
	`CHK_ASSERT(a_occ_max, clk, arst_n, rsp_valid |-> (occupancy <= CNT_W'(DEPTH)), "occupancy above depth")
	`CHK_NEVER(a_flags_excl, clk, arst_n, rsp_valid && ((out_valid && (found || overflow)) || (found && overflow)), "result flags not exclusive")
	`CHK_ASSERT(a_ovf_full, clk, arst_n, (rsp_valid && overflow) |-> (occupancy == CNT_W'(DEPTH)), "overflow while not full")
	`CHK_ASSERT(a_key_zero, clk, arst_n, (rsp_valid && !out_valid) |-> (out_key == '0), "key returned without evict")

endmodule

bind lru_order_list lru_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.out_key   (rsp.out_key),
	.out_valid (rsp.out_valid),
	.found     (rsp.found),
	.overflow  (rsp.overflow),
	.occupancy (rsp.occupancy)
);

// ===== verif/lru_order_list_checker.sv =====
`timescale 1ns / 100ps
// Checker for the LRU order list: watches req and rsp, predicts each response
// word from its own copy of the list and compares it field by field.
// Depends on lru_pkg, lru_req_if and lru_rsp_if.
module lru_order_list_checker import lru_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	lru_req_if   req,
	lru_rsp_if   rsp,
	output int   mismatches,
	output int   pending,
	output int   checked,
	output int   dropped,
	output int   empty_evicts,
	output int   hits
);

	typedef struct packed {
		logic [KEY_W-1:0] out_key;
		logic             out_valid;
		logic             found;
		logic             overflow;
		logic [CNT_W-1:0] occupancy;
	} reply_t;

	logic [KEY_W-1:0] slots [DEPTH];   // oldest at 0
	int               held;
	reply_t           replies_due [$];
	reply_t           got;
	reply_t           want;

	// close the hole at pos, newer keys slide down
	function automatic void drop_slot(int pos);
		for (int i = pos; i + 1 < held; i++)
			slots[i] = slots[i + 1];
		held--;
	endfunction

	function automatic reply_t lru_apply(op_t act, logic [KEY_W-1:0] k);
		reply_t r;
		bit     hit;
		int     i;
		r   = '0;
		hit = 1'b0;
		case (act)
			OP_APPEND: begin
				if (held >= DEPTH) begin
					r.overflow = 1'b1;
				end else begin
					slots[held] = k;
					held++;
				end
			end
			OP_EVICT: begin
				if (held > 0) begin
					r.out_key   = slots[0];
					r.out_valid = 1'b1;
					drop_slot(0);
				end
			end
			OP_TOUCH: begin
				// newest match moves to the newest end
				for (i = held - 1; i >= 0 && !hit; i--) begin
					if (slots[i] == k) begin
						hit = 1'b1;
						drop_slot(i);
						slots[held] = k;
						held++;
					end
				end
			end
			default: begin
				// remove: oldest match goes
				for (i = 0; i < held && !hit; i++) begin
					if (slots[i] == k) begin
						hit = 1'b1;
						drop_slot(i);
					end
				end
			end
		endcase
		r.found     = hit;
		r.occupancy = held[CNT_W-1:0];
		return r;
	endfunction

	task automatic note_mismatch(string what);
		if (mismatches < 10)
			$display("%0t mismatch (%s): expected key %h valid %b found %b ovf %b occ %0d, got key %h valid %b found %b ovf %b occ %0d",
				$realtime, what,
				want.out_key, want.out_valid, want.found, want.overflow, want.occupancy,
				got.out_key, got.out_valid, got.found, got.overflow, got.occupancy);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held         = 0;
			replies_due.delete();
			mismatches   = 0;
			checked      = 0;
			dropped      = 0;
			empty_evicts = 0;
			hits         = 0;
			pending      <= 0;
		end else begin
			// responses first: none can belong to a request taken at this edge
			if (rsp.valid && rsp.ready) begin
				got.out_key   = rsp.out_key;
				got.out_valid = rsp.out_valid;
				got.found     = rsp.found;
				got.overflow  = rsp.overflow;
				got.occupancy = rsp.occupancy;
				if (replies_due.size() == 0) begin
					want = '0;
					note_mismatch("no word expected");
				end else begin
					want = replies_due.pop_front();
					checked++;
					if (got.out_key !== want.out_key || got.out_valid !== want.out_valid ||
						got.found !== want.found || got.overflow !== want.overflow ||
						got.occupancy !== want.occupancy)
						note_mismatch("wrong field");
				end
			end
			if (req.valid && req.ready) begin
				want = lru_apply(op_t'(req.action), req.key);
				replies_due.push_back(want);
				if (want.overflow)
					dropped++;
				if (op_t'(req.action) == OP_EVICT && !want.out_valid)
					empty_evicts++;
				if (want.found)
					hits++;
			end
			pending <= replies_due.size();
		end
	end

endmodule

// ===== verif/lru_order_list_tb.sv =====
`timescale 1ns / 100ps
// Top of the LRU order list testbench: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict.
// Depends on lru_pkg, lru_req_if, lru_rsp_if, lru_order_list and the checker.
module lru_order_list_tb;
	import lru_pkg::*;

	// Idle cycles with no word on either channel before the run is called hung.
	// Worst correct case is a long request gap plus a long response stall plus
	// the back end's match and apply steps.
	localparam int IDLE_LIMIT  = 4000;
	// Cycles to wait after the last response so a stray extra word gets caught.
	localparam int TAIL_CYCLES = 20;
	localparam int POOL_SIZE   = 8;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 100;

	// Action mix of a random phase: fill pushes the list toward full,
	// drain toward empty, even sits in between.
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   quiet  = 1'b0;   // no gaps and no stalls while set
	int   sent   = 0;
	int   idle_cycles = 0;
	int   resp_stall;
	int   resp_next;
	int   mismatches, pending, checked, dropped, empty_evicts, hits;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	lru_req_if req ();
	lru_rsp_if rsp ();

	lru_order_list u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	lru_order_list_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.mismatches   (mismatches),
		.pending      (pending),
		.checked      (checked),
		.dropped      (dropped),
		.empty_evicts (empty_evicts),
		.hits         (hits)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Gap length for either side: mostly none or short, now and then long
	// enough that the back end drains or the queue fills behind a stall.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic op_t pick_action(mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				if (r < 55) return OP_APPEND;
				if (r < 65) return OP_EVICT;
				if (r < 85) return OP_TOUCH;
				return OP_REMOVE;
			end
			MIX_DRAIN: begin
				if (r < 15) return OP_APPEND;
				if (r < 50) return OP_EVICT;
				if (r < 65) return OP_TOUCH;
				return OP_REMOVE;
			end
			default: begin
				if (r < 30) return OP_APPEND;
				if (r < 50) return OP_EVICT;
				if (r < 75) return OP_TOUCH;
				return OP_REMOVE;
			end
		endcase
	endfunction

	// Keys come mostly from a small pool so touch and remove find matches
	// and duplicates pile up; the rest are fresh 32-bit values (misses).
	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	// Present one request word and hold it until the block takes it.
	// valid stays high into the next word when there is no gap.
	task automatic send_word(op_t act, logic [KEY_W-1:0] k);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid  <= 1'b1;
		req.action <= act;
		req.key    <= k;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sent++;
	endtask

	// Response back-pressure: after each taken word, maybe stall a while.
	initial begin
		rsp.ready  = 1'b0;
		resp_stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				resp_next = pick_gap();
			else if (resp_stall > 0)
				resp_next = resp_stall - 1;
			else
				resp_next = 0;
			resp_stall = resp_next;
			rsp.ready <= (resp_next == 0);
		end
	end

	// Watchdog: ends the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		logic [KEY_W-1:0] k;
		mix_t             mix;
		int               i;
		int               phase;
		req.valid  = 1'b0;
		req.action = OP_APPEND;
		req.key    = '0;
		for (i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: operations on the empty list first; the key is ignored
		// by evict, so give it a nonzero one.
		send_word(OP_EVICT, 32'h1234_5678);
		send_word(OP_TOUCH, '0);
		send_word(OP_REMOVE, '1);

		// Fill to capacity with the key extremes, both bit checkerboards and
		// one duplicated key, then one append past full (dropped).
		for (i = 0; i < DEPTH; i++) begin
			case (i)
				0:       k = '0;
				1:       k = '1;
				2, 9:    k = 32'h5555_5555;
				3:       k = 32'hAAAA_AAAA;
				default: k = 32'h0000_1000 + i;
			endcase
			send_word(OP_APPEND, k);
		end
		send_word(OP_APPEND, 32'hDEAD_BEEF);

		// Touch the newest key (no reorder), then an older one, then the
		// duplicated key: only its newest copy should move.
		send_word(OP_TOUCH, 32'h0000_1000 + DEPTH - 1);
		send_word(OP_TOUCH, '1);
		send_word(OP_TOUCH, 32'h5555_5555);
		// Remove a single key and the oldest copy of the duplicate.
		send_word(OP_REMOVE, 32'hAAAA_AAAA);
		send_word(OP_REMOVE, 32'h5555_5555);
		// Evict returns the all-zero key, then a remove that misses.
		send_word(OP_EVICT, '0);
		send_word(OP_REMOVE, 32'h0BAD_0BAD);

		// Random phases. Drain first so the list empties by evict and by
		// remove; up to half the pool is swapped per phase so old keys linger.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase % 3)
				0:       mix = MIX_DRAIN;
				1:       mix = MIX_FILL;
				default: mix = MIX_EVEN;
			endcase
			quiet = (phase == 3 || phase == 6);
			for (i = 0; i < POOL_SIZE / 2; i++)
				key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
			for (i = 0; i < PHASE_ITEMS; i++)
				send_word(pick_action(mix), pick_key());
		end
		req.valid <= 1'b0;
		quiet = 1'b0;

		// One edge so the checker has counted the last request, then drain.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d request words, %0d response words checked", sent, checked);
		$display("appends dropped when full %0d, evicts on empty %0d, touch/remove hits %0d",
			dropped, empty_evicts, hits);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
